// ----- rtl/convex_polygon_minkowski_sum_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the convex polygon Minkowski sum block
// Each macro gives one clocked implication that is disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef CONVEX_POLYGON_MINKOWSKI_SUM_ASSERT_SVH
`define CONVEX_POLYGON_MINKOWSKI_SUM_ASSERT_SVH

// Same-cycle implication.
`define CPMS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpms assertion failed");

// Next-cycle implication.
`define CPMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpms assertion failed");

`endif

// ----- rtl/cpms_pkg.sv -----
// ---------------------------------------------------------------------------
// cpms_pkg
// Shared constants and types of the convex polygon Minkowski sum block.
// ---------------------------------------------------------------------------
package cpms_pkg;

  localparam int MAX_VERTS = 32;
  localparam int AW        = $clog2(MAX_VERTS);
  localparam int CW        = $clog2(MAX_VERTS + 1);
  localparam int ACC_W     = 40;

  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } vertex_t;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
  } evec_t;

  typedef struct packed {
    logic wr_en;
    logic scan_start;
    logic fetch;
    logic load_cur;
    logic load_nxt;
    logic shift;
    logic clear;
  } poly_cmd_t;

  typedef struct packed {
    logic [CW-1:0] count;
    logic          full;
    logic          done;
  } poly_stat_t;

endpackage

// ----- rtl/cpms_ram.sv -----
// ---------------------------------------------------------------------------
// cpms_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module cpms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/cpms_poly.sv -----
// ---------------------------------------------------------------------------
// cpms_poly
// Vertex store of one polygon with its orientation and start-vertex scan
// and a walker that streams the vertices in normalized order.
// ---------------------------------------------------------------------------
module cpms_poly (
  input  logic                 clk,
  input  logic                 rst,
  input  cpms_pkg::poly_cmd_t  cmd,
  input  cpms_pkg::vertex_t    wr_vert,
  output cpms_pkg::poly_stat_t stat,
  output cpms_pkg::vertex_t    cur,
  output cpms_pkg::evec_t      edg
);
  import cpms_pkg::*;

  logic [CW-1:0] count;
  logic          full;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rdata;
  vertex_t       rv;

  // Scan pipeline.
  logic                    sc_active;
  logic [CW-1:0]           sc_idx;
  logic                    d_vld;
  logic [CW-1:0]           d_idx;
  vertex_t                 prev;
  logic                    p_vld;
  logic signed [31:0]      p1;
  logic signed [31:0]      p2;
  logic signed [ACC_W-1:0] acc;
  logic                    fin1;
  logic                    fin2;
  logic                    done;
  vertex_t                 min_v;
  logic [AW-1:0]           s_first;
  logic [AW-1:0]           s_last;

  // Walker.
  logic          dir;
  logic [AW-1:0] ptr;
  logic [AW-1:0] cnt_m1;
  vertex_t       nxt;

  assign full   = (count == CW'(MAX_VERTS));
  assign rv     = vertex_t'(rdata);
  assign cnt_m1 = AW'(count - CW'(1));

  assign rd_addr = sc_active ? ((sc_idx == count) ? '0 : sc_idx[AW-1:0]) : ptr;

  cpms_ram #(.WIDTH(32), .DEPTH(MAX_VERTS)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en && !full),
    .waddr (count[AW-1:0]),
    .wdata (wr_vert),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
    end else if (cmd.wr_en && !full) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_active <= 1'b0;
      d_vld     <= 1'b0;
      p_vld     <= 1'b0;
      fin1      <= 1'b0;
      fin2      <= 1'b0;
      done      <= 1'b0;
    end else begin
      d_vld <= 1'b0;
      p_vld <= 1'b0;
      fin1  <= d_vld && (d_idx == count);
      fin2  <= fin1;
      if (cmd.scan_start) begin
        sc_active <= 1'b1;
        sc_idx    <= '0;
        done      <= 1'b0;
        acc       <= '0;
      end else if (sc_active) begin
        d_vld  <= 1'b1;
        d_idx  <= sc_idx;
        sc_idx <= sc_idx + CW'(1);
        if (sc_idx == count) begin
          sc_active <= 1'b0;
        end
      end
      if (d_vld) begin
        prev <= rv;
        if (d_idx != '0) begin
          p_vld <= 1'b1;
          p1    <= prev.x * rv.y;
          p2    <= rv.x * prev.y;
        end
        if (d_idx == '0) begin
          min_v   <= rv;
          s_first <= '0;
          s_last  <= '0;
        end else if (d_idx != count) begin
          if (rv.y < min_v.y || (rv.y == min_v.y && rv.x < min_v.x)) begin
            min_v   <= rv;
            s_first <= d_idx[AW-1:0];
            s_last  <= d_idx[AW-1:0];
          end else if (rv.y == min_v.y && rv.x == min_v.x) begin
            s_last <= d_idx[AW-1:0];
          end
        end
      end
      if (p_vld) begin
        acc <= acc + ACC_W'($signed({p1[31], p1}) - $signed({p2[31], p2}));
      end
      // A clockwise polygon is walked backward from its last lowest vertex,
      // which is the first one in reversed order.
      if (fin2) begin
        done <= 1'b1;
        dir  <= acc[ACC_W-1];
        ptr  <= acc[ACC_W-1] ? s_last : s_first;
      end else if (cmd.fetch) begin
        if (dir) begin
          ptr <= (ptr == '0) ? cnt_m1 : ptr - AW'(1);
        end else begin
          ptr <= (ptr == cnt_m1) ? '0 : ptr + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cur) begin
      cur <= rv;
    end else if (cmd.shift) begin
      cur <= nxt;
    end
    if (cmd.load_nxt) begin
      nxt <= rv;
    end
  end

  assign edg.x = {nxt.x[15], nxt.x} - {cur.x[15], cur.x};
  assign edg.y = {nxt.y[15], nxt.y} - {cur.y[15], cur.y};

  assign stat.count = count;
  assign stat.full  = full;
  assign stat.done  = done;

endmodule

// ----- rtl/convex_polygon_minkowski_sum.sv -----
// ---------------------------------------------------------------------------
// convex_polygon_minkowski_sum
// Minkowski sum of two convex polygons held in on-chip vertex memories.
// ---------------------------------------------------------------------------
// A vertex load does not raise busy: busy stays low and loads may follow
// back to back. A compute transfer keeps busy high through a scan of both
// stores, walker priming in S_F0, S_F1 and S_F2, then S_MUL, S_DEC and
// S_WAIT per result, the last result skipping S_WAIT. Each strobe comes from
// registers set in S_DEC; the last comes with busy already low.
// An empty run strobes the cycle after its transfer. Sync reset clears state.
module convex_polygon_minkowski_sum (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic signed [15:0] x_coord,
  input  logic signed [15:0] y_coord,
  output logic               valid,
  output logic signed [16:0] sum_x,
  output logic signed [16:0] sum_y,
  output logic               is_empty,
  output logic               overflowed,
  output logic               last
);
  import cpms_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_F0   = 3'd2;
  localparam logic [2:0] S_F1   = 3'd3;
  localparam logic [2:0] S_F2   = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_DEC  = 3'd6;
  localparam logic [2:0] S_WAIT = 3'd7;

  logic [2:0] state;
  logic       ovf;

  poly_cmd_t  cmd_a, cmd_b;
  poly_stat_t stat_a, stat_b;
  vertex_t    cur_a, cur_b;
  evec_t      ea, eb;
  vertex_t    wr_vert;

  // Merge state: edge indexes, running vertex and registered cross terms.
  logic [CW-1:0]      i, j;
  logic signed [16:0] cx, cy;
  logic signed [33:0] pa, pb;
  logic               adv_a, adv_b;

  logic               accept;
  logic               a_live, b_live;
  logic signed [34:0] cr;
  logic               take_a, take_b;
  logic               step_a, step_b;
  logic [CW-1:0]      i_next, j_next;
  logic               fin;

  assign wr_vert.x = x_coord;
  assign wr_vert.y = y_coord;
  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);

  cpms_poly u_poly_a (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_a),
    .wr_vert (wr_vert),
    .stat    (stat_a),
    .cur     (cur_a),
    .edg     (ea)
  );

  cpms_poly u_poly_b (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_b),
    .wr_vert (wr_vert),
    .stat    (stat_b),
    .cur     (cur_b),
    .edg     (eb)
  );

  // Edge selection: the sign of the cross product picks the A edge, the B
  // edge, or both when they are parallel. An exhausted side is never taken.
  assign a_live = (i < stat_a.count);
  assign b_live = (j < stat_b.count);
  assign cr     = $signed({pa[33], pa}) - $signed({pb[33], pb});
  assign take_a = !b_live || (a_live && (cr > 0));
  assign take_b = !take_a && (!a_live || (cr < 0));
  assign step_a = take_a || !take_b;
  assign step_b = take_b || !take_a;
  assign i_next = step_a ? i + CW'(1) : i;
  assign j_next = step_b ? j + CW'(1) : j;
  assign fin    = (i_next >= stat_a.count) && (j_next >= stat_b.count);

  always_comb begin
    cmd_a = '0;
    cmd_b = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_LOAD_A) begin
            cmd_a.wr_en = 1'b1;
          end else if (op == OP_LOAD_B) begin
            cmd_b.wr_en = 1'b1;
          end else if (op == OP_COMPUTE) begin
            if (stat_a.count == '0 || stat_b.count == '0) begin
              cmd_a.clear = 1'b1;
              cmd_b.clear = 1'b1;
            end else begin
              cmd_a.scan_start = 1'b1;
              cmd_b.scan_start = 1'b1;
            end
          end
        end
      end
      S_F0: begin
        cmd_a.fetch = 1'b1;
        cmd_b.fetch = 1'b1;
      end
      S_F1: begin
        cmd_a.load_cur = 1'b1;
        cmd_b.load_cur = 1'b1;
        cmd_a.fetch    = 1'b1;
        cmd_b.fetch    = 1'b1;
      end
      S_F2: begin
        cmd_a.load_nxt = 1'b1;
        cmd_b.load_nxt = 1'b1;
      end
      S_DEC: begin
        if (fin) begin
          cmd_a.clear = 1'b1;
          cmd_b.clear = 1'b1;
        end else begin
          cmd_a.shift = step_a;
          cmd_a.fetch = step_a;
          cmd_b.shift = step_b;
          cmd_b.fetch = step_b;
        end
      end
      S_WAIT: begin
        cmd_a.load_nxt = adv_a;
        cmd_b.load_nxt = adv_b;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ovf   <= 1'b0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if ((op == OP_LOAD_A && stat_a.full) || (op == OP_LOAD_B && stat_b.full)) begin
              ovf <= 1'b1;
            end
            if (op == OP_COMPUTE) begin
              if (stat_a.count == '0 || stat_b.count == '0) begin
                valid      <= 1'b1;
                sum_x      <= '0;
                sum_y      <= '0;
                is_empty   <= 1'b1;
                overflowed <= ovf;
                last       <= 1'b1;
                ovf        <= 1'b0;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (stat_a.done && stat_b.done) begin
            state <= S_F0;
          end
        end
        S_F0: begin
          state <= S_F1;
        end
        S_F1: begin
          state <= S_F2;
        end
        S_F2: begin
          // A single-vertex polygon has no edges: the other one is walked
          // alone, which translates it by that vertex.
          cx    <= {cur_a.x[15], cur_a.x} + {cur_b.x[15], cur_b.x};
          cy    <= {cur_a.y[15], cur_a.y} + {cur_b.y[15], cur_b.y};
          i     <= (stat_a.count == CW'(1)) ? stat_a.count : '0;
          j     <= (stat_b.count == CW'(1) && stat_a.count != CW'(1)) ? stat_b.count : '0;
          state <= S_MUL;
        end
        S_MUL: begin
          pa    <= ea.x * eb.y;
          pb    <= ea.y * eb.x;
          state <= S_DEC;
        end
        S_DEC: begin
          valid      <= 1'b1;
          sum_x      <= cx;
          sum_y      <= cy;
          is_empty   <= 1'b0;
          overflowed <= ovf;
          last       <= fin;
          cx <= cx + (step_a ? ea.x : 17'sd0) + (step_b ? eb.x : 17'sd0);
          cy <= cy + (step_a ? ea.y : 17'sd0) + (step_b ? eb.y : 17'sd0);
          i     <= i_next;
          j     <= j_next;
          adv_a <= step_a;
          adv_b <= step_b;
          if (fin) begin
            ovf   <= 1'b0;
            state <= S_IDLE;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_MUL;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/cpms_checker.sv -----
// ---------------------------------------------------------------------------
// cpms_checker
// Port-level checks of the Minkowski sum block, bound to the top level.
// ---------------------------------------------------------------------------
`include "convex_polygon_minkowski_sum_assert.svh"

module cpms_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] op,
  input logic       valid,
  input logic       is_empty,
  input logic       last
);
  import cpms_pkg::*;

  // A run that still has results to give keeps the block busy.
  `CPMS_ASSERT_NOW(a_mid_busy, clk, rst, valid && !last, busy)
  // The empty result is the only one of its run.
  `CPMS_ASSERT_NOW(a_empty_last, clk, rst, valid && is_empty, last)
  // Right after a finished run only an empty run can strobe at once.
  `CPMS_ASSERT_NEXT(a_last_quiet, clk, rst, valid && last, !valid || is_empty)
  // Loading a vertex gives no result.
  `CPMS_ASSERT_NEXT(a_load_quiet, clk, rst,
    start && !busy && (op == OP_LOAD_A || op == OP_LOAD_B), !valid)

endmodule

bind convex_polygon_minkowski_sum cpms_checker u_cpms_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .op       (op),
  .valid    (valid),
  .is_empty (is_empty),
  .last     (last)
);

// ----- sim/tb_convex_polygon_minkowski_sum.sv -----
// ---------------------------------------------------------------------------
// Testbench for convex_polygon_minkowski_sum
// Loads random convex and broken polygons into both stores, issues compute
// commands and checks every emitted sum vertex against an in-bench predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// One expected or observed sum vertex.
typedef struct {
  logic signed [16:0] x;
  logic signed [16:0] y;
  logic               empty;
  logic               ovf;
  logic               last;
} sum_vertex_t;

class minkowski_scoreboard;
  localparam int NV = cpms_pkg::MAX_VERTS;

  // Predictor copy of the block's stores and flags.
  longint ax_store[NV], ay_store[NV], bx_store[NV], by_store[NV];
  int     na_cnt, nb_cnt;
  bit     ovf_flag;
  sum_vertex_t pending_q[$];
  int     mismatches;
  int     vertices_seen;
  int     runs_seen;

  function new();
    na_cnt = 0;
    nb_cnt = 0;
    ovf_flag = 0;
    mismatches = 0;
    vertices_seen = 0;
    runs_seen = 0;
  endfunction

  // Reverse if clockwise, then rotate to the lowest-y, lowest-x vertex.
  function void orient(ref longint px[NV], ref longint py[NV], input int n);
    longint tx[NV], ty[NV];
    longint area;
    longint t;
    int s;
    area = 0;
    s = 0;
    if (n <= 1) return;
    for (int i = 0; i < n; i++)
      area += px[i] * py[(i + 1) % n] - px[(i + 1) % n] * py[i];
    if (area < 0) begin
      for (int i = 0; i < n / 2; i++) begin
        t = px[i]; px[i] = px[n - 1 - i]; px[n - 1 - i] = t;
        t = py[i]; py[i] = py[n - 1 - i]; py[n - 1 - i] = t;
      end
    end
    for (int i = 1; i < n; i++)
      if (py[i] < py[s] || (py[i] == py[s] && px[i] < px[s])) s = i;
    for (int i = 0; i < n; i++) begin
      tx[i] = px[(i + s) % n];
      ty[i] = py[(i + s) % n];
    end
    for (int i = 0; i < n; i++) begin
      px[i] = tx[i];
      py[i] = ty[i];
    end
  endfunction

  function void push_vertex(longint x, longint y, bit empty);
    sum_vertex_t v;
    v.x = x[16:0];
    v.y = y[16:0];
    v.empty = empty;
    v.ovf = ovf_flag;
    v.last = 0;
    pending_q.insert(pending_q.size(), v);
  endfunction

  // Notes one accepted command transfer.
  function void note_command(logic [1:0] op, logic signed [15:0] x,
                             logic signed [15:0] y);
    longint ax[NV], ay[NV], bx[NV], by[NV];
    longint eax[NV], eay[NV], ebx[NV], eby[NV];
    longint cx, cy, cr;
    int i, j;
    if (op == cpms_pkg::OP_LOAD_A || op == cpms_pkg::OP_LOAD_B) begin
      if (op == cpms_pkg::OP_LOAD_A) begin
        if (na_cnt >= NV) ovf_flag = 1;
        else begin
          ax_store[na_cnt] = x; ay_store[na_cnt] = y; na_cnt++;
        end
      end else begin
        if (nb_cnt >= NV) ovf_flag = 1;
        else begin
          bx_store[nb_cnt] = x; by_store[nb_cnt] = y; nb_cnt++;
        end
      end
      return;
    end
    if (op != cpms_pkg::OP_COMPUTE) return;
    runs_seen++;
    if (na_cnt == 0 || nb_cnt == 0) begin
      push_vertex(0, 0, 1);
    end else begin
      ax = ax_store; ay = ay_store; bx = bx_store; by = by_store;
      orient(ax, ay, na_cnt);
      orient(bx, by, nb_cnt);
      if (na_cnt == 1) begin
        for (i = 0; i < nb_cnt; i++) push_vertex(bx[i] + ax[0], by[i] + ay[0], 0);
      end else if (nb_cnt == 1) begin
        for (i = 0; i < na_cnt; i++) push_vertex(ax[i] + bx[0], ay[i] + by[0], 0);
      end else begin
        for (i = 0; i < na_cnt; i++) begin
          eax[i] = ax[(i + 1) % na_cnt] - ax[i];
          eay[i] = ay[(i + 1) % na_cnt] - ay[i];
        end
        for (i = 0; i < nb_cnt; i++) begin
          ebx[i] = bx[(i + 1) % nb_cnt] - bx[i];
          eby[i] = by[(i + 1) % nb_cnt] - by[i];
        end
        cx = ax[0] + bx[0];
        cy = ay[0] + by[0];
        i = 0;
        j = 0;
        while (i < na_cnt || j < nb_cnt) begin
          cr = 0;
          push_vertex(cx, cy, 0);
          if (i < na_cnt && j < nb_cnt) cr = eax[i] * eby[j] - eay[i] * ebx[j];
          if (j == nb_cnt || (i < na_cnt && cr > 0)) begin
            cx += eax[i]; cy += eay[i]; i++;
          end else if (i == na_cnt || cr < 0) begin
            cx += ebx[j]; cy += eby[j]; j++;
          end else begin
            cx += eax[i] + ebx[j]; cy += eay[i] + eby[j]; i++; j++;
          end
        end
      end
    end
    pending_q[pending_q.size() - 1].last = 1;
    na_cnt = 0;
    nb_cnt = 0;
    ovf_flag = 0;
  endfunction

  // Checks one observed result against the oldest expectation.
  function void check_result(sum_vertex_t got);
    sum_vertex_t want;
    vertices_seen++;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected result x=%0d y=%0d empty=%0b", got.x, got.y,
                 got.empty);
      return;
    end
    want = pending_q.pop_front();
    if (got.x !== want.x || got.y !== want.y || got.empty !== want.empty ||
        got.ovf !== want.ovf || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: expected x=%0d y=%0d e=%0b o=%0b l=%0b, got x=%0d y=%0d e=%0b o=%0b l=%0b",
                 want.x, want.y, want.empty, want.ovf, want.last,
                 got.x, got.y, got.empty, got.ovf, got.last);
    end
  endfunction
endclass

module tb_convex_polygon_minkowski_sum;
  import cpms_pkg::*;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         op;
  logic signed [15:0] x_coord;
  logic signed [15:0] y_coord;
  logic               valid;
  logic signed [16:0] sum_x;
  logic signed [16:0] sum_y;
  logic               is_empty;
  logic               overflowed;
  logic               last;

  minkowski_scoreboard sb;
  // Percent chance that the sender leaves a cycle empty.
  int idle_pct;
  int items_sent;

  convex_polygon_minkowski_sum uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .x_coord(x_coord), .y_coord(y_coord), .valid(valid), .sum_x(sum_x),
    .sum_y(sum_y), .is_empty(is_empty), .overflowed(overflowed), .last(last)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Every result strobe is a transfer; the receiver cannot refuse it.
  always @(posedge clk) begin
    sum_vertex_t got;
    if (!rst && valid) begin
      got.x = sum_x;
      got.y = sum_y;
      got.empty = is_empty;
      got.ovf = overflowed;
      got.last = last;
      sb.check_result(got);
    end
  end

  // Issues one command. A transfer happens at the edge where start is high
  // and busy is low; the scoreboard is told about it at that edge. Start is
  // lowered only when the sender goes idle, so back-to-back transfers keep it high.
  task automatic send_cmd(input logic [1:0] o, input logic signed [15:0] x,
                          input logic signed [15:0] y);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    x_coord <= x;
    y_coord <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(o, x, y);
    items_sent++;
  endtask

  task automatic go_quiet();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected vertex has come out.
  task automatic drain();
    go_quiet();
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // Loads a convex polygon: points on a circle at evenly spaced angles, in
  // either direction, around a random center. Sizes are kept moderate.
  task automatic load_convex(input logic [1:0] o, input int n, input int radius);
    int cxc, cyc, start_k;
    bit cw;
    real ang;
    cxc = $urandom_range(2 * (32767 - radius)) - (32767 - radius);
    cyc = $urandom_range(2 * (32767 - radius)) - (32767 - radius);
    cw = $urandom_range(1);
    start_k = $urandom_range(n - 1);
    for (int k = 0; k < n; k++) begin
      ang = 6.283185307 * ((start_k + (cw ? n - k : k)) % n) / n;
      send_cmd(o, 16'(cxc + $rtoi(radius * $cos(ang))),
               16'(cyc + $rtoi(radius * $sin(ang))));
    end
  endtask

  task automatic load_noise(input logic [1:0] o, input int n);
    for (int k = 0; k < n; k++) send_cmd(o, 16'($urandom), 16'($urandom));
  endtask

  task automatic random_run();
    int na, nb, pick;
    pick = $urandom_range(99);
    na = (pick < 5) ? 0 : (pick < 12) ? 1 : (pick < 16) ? 32 : $urandom_range(8, 2);
    pick = $urandom_range(99);
    nb = (pick < 5) ? 0 : (pick < 12) ? 1 : (pick < 16) ? 32 : $urandom_range(8, 2);
    if ($urandom_range(9) == 0) begin
      load_noise(OP_LOAD_A, na);
      load_noise(OP_LOAD_B, nb);
    end else begin
      if (na > 0) load_convex(OP_LOAD_A, na, $urandom_range(16000, 3 + na));
      if (nb > 0) load_convex(OP_LOAD_B, nb, $urandom_range(16000, 3 + nb));
    end
    if ($urandom_range(9) == 0) send_cmd(2'd3, 16'($urandom), 16'($urandom));
    if ($urandom_range(14) == 0) send_cmd(OP_LOAD_A, 16'($urandom), 16'($urandom));
    send_cmd(OP_COMPUTE, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    sb = new();
    idle_pct = 0;
    items_sent = 0;
    rst = 1'b1;
    start = 1'b0;
    op = OP_LOAD_A;
    x_coord = '0;
    y_coord = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty polygons, single vertex, extremes, overflow.
    send_cmd(OP_COMPUTE, 0, 0);
    send_cmd(OP_LOAD_A, 16'sh7fff, 16'sh7fff);
    send_cmd(OP_COMPUTE, 0, 0);
    send_cmd(OP_LOAD_A, -16'sd32768, -16'sd32768);
    send_cmd(OP_LOAD_B, -16'sd32768, -16'sd32768);
    send_cmd(OP_COMPUTE, 16'hffff, 16'hffff);
    send_cmd(OP_LOAD_A, 16'sh7fff, 16'sh7fff);
    send_cmd(OP_LOAD_B, 0, 0);
    send_cmd(OP_LOAD_B, 16'sh7fff, 0);
    send_cmd(OP_LOAD_B, 16'sh7fff, 16'sh7fff);
    send_cmd(OP_LOAD_B, 0, 16'sh7fff);
    send_cmd(2'd3, 16'h5555, 16'haaaa);
    send_cmd(OP_COMPUTE, 0, 0);
    // Two squares, one clockwise: parallel edges take the summed branch.
    send_cmd(OP_LOAD_A, -16'sd32768, -16'sd32768);
    send_cmd(OP_LOAD_A, -16'sd32768, 16'sh7fff);
    send_cmd(OP_LOAD_A, 16'sh7fff, 16'sh7fff);
    send_cmd(OP_LOAD_A, 16'sh7fff, -16'sd32768);
    send_cmd(OP_LOAD_B, 0, 0);
    send_cmd(OP_LOAD_B, 10, 0);
    send_cmd(OP_LOAD_B, 10, 10);
    send_cmd(OP_LOAD_B, 0, 10);
    send_cmd(OP_COMPUTE, 0, 0);
    // Store full on both sides, from non-convex noise loads.
    load_noise(OP_LOAD_A, 34);
    load_noise(OP_LOAD_B, 33);
    send_cmd(OP_COMPUTE, 0, 0);
    drain();

    // Random part in idling phases; the pause at each drain waits out all results.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 86 : (ph == 2) ? 0 : 37;
      for (int r = 0; r < 5; r++) random_run();
      drain();
    end

    repeat (200) @(posedge clk);
    $display("Covered %0d command transfers, %0d compute runs, %0d result vertices.",
             items_sent, sb.runs_seen, sb.vertices_seen);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("Mismatches: %0d, leftover expectations: %0d", sb.mismatches,
               sb.pending_q.size());
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- convex_polygon_minkowski_sum.f -----
+incdir+rtl
rtl/cpms_pkg.sv
rtl/cpms_ram.sv
rtl/cpms_poly.sv
rtl/convex_polygon_minkowski_sum.sv
rtl/cpms_checker.sv
sim/tb_convex_polygon_minkowski_sum.sv
